@@ src/fifo_with_cancel_and_search_core_macros.svh @@
// Assertion macros shared by the queue checker.
`ifndef FIFO_WITH_CANCEL_AND_SEARCH_CORE_MACROS_SVH
`define FIFO_WITH_CANCEL_AND_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication, quiet during reset.
`define FCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

// Next-cycle implication that also holds across reset.
`define FCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ src/fcs_pkg.sv @@
// Types and codes for the cancelable search queue.
package fcs_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_FIND_H = 3'd3,
        KIND_FIND_ID = 3'd4
    } t_kind;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [15:0] item_id;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle_out;
        logic [15:0] id_out;
        logic [4:0]  count;
    } t_out_beat;

    typedef struct packed {
        logic cmp;
        logic search;
        logic by_id;
        logic head_only;
        logic push;
        logic remove;
    } t_cell_ctl;

endpackage

@@ src/fcs_cell.sv @@
// One queue slot: holds a handle/id pair, matches a key, shifts from its neighbor.
module fcs_cell #(
    parameter int HANDLE_BITS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fcs_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_occ,
    input  logic                   i_tail,
    input  logic                   i_head,
    input  logic [HANDLE_BITS-1:0] i_key_h,
    input  logic [ID_BITS-1:0]     i_key_id,
    input  logic [HANDLE_BITS-1:0] i_nxt_h,
    input  logic [ID_BITS-1:0]     i_nxt_id,
    input  logic                   i_seen,
    output logic                   o_seen,
    output logic                   o_first,
    output logic [HANDLE_BITS-1:0] o_h,
    output logic [ID_BITS-1:0]     o_id
);

    logic                   r_hit;
    logic                   n_hit;
    logic [HANDLE_BITS-1:0] r_h;
    logic [HANDLE_BITS-1:0] n_h;
    logic [ID_BITS-1:0]     r_id;
    logic [ID_BITS-1:0]     n_id;

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.cmp) begin
            if (i_ctl.head_only) begin
                n_hit = i_head & i_occ;
            end else if (i_ctl.search) begin
                if (i_ctl.by_id) begin
                    n_hit = i_occ & (r_id == i_key_id);
                end else begin
                    n_hit = i_occ & (i_key_h != '0) & (r_h == i_key_h);
                end
            end else begin
                n_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_h  = r_h;
        n_id = r_id;
        if (i_ctl.push && i_tail) begin
            n_h  = i_key_h;
            n_id = i_key_id;
        end else if (i_ctl.remove && (i_seen || r_hit)) begin
            n_h  = i_nxt_h;
            n_id = i_nxt_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h  <= n_h;
        r_id <= n_id;
    end

    assign o_seen  = i_seen | r_hit;
    assign o_first = r_hit & ~i_seen;
    assign o_h     = r_h;
    assign o_id    = r_id;

endmodule

@@ src/fifo_with_cancel_and_search_core.sv @@
// Top level of the cancelable search queue: control, count and the row of slots.
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------
//  in      | to block  | i_in_valid / o_in_stall | fcs_pkg::t_in_beat
//  out     | from block| o_out_valid / i_out_stall| fcs_pkg::t_out_beat
//
// Each request steps through accept, parallel compare in every slot,
// then first-match priority along the slot row with shift and result load.
// The next request is accepted while a result waits in the output register.
// A stalled result holds the execute step; the input stalls meanwhile.
// Synchronous reset empties the queue and drops any pending result.
module fifo_with_cancel_and_search_core #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fcs_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fcs_pkg::t_out_beat  o_out_beat
);

    localparam int CW = $clog2(DEPTH + 1);

    fcs_pkg::t_state        r_state;
    fcs_pkg::t_state        n_state;
    fcs_pkg::t_kind         r_kind;
    logic [HANDLE_BITS-1:0] r_key_h;
    logic [ID_BITS-1:0]     r_key_id;
    logic [HANDLE_BITS-1:0] in_h;
    logic [ID_BITS-1:0]     in_id;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic                   n_out_valid;
    fcs_pkg::t_out_beat     r_out;
    fcs_pkg::t_out_beat     n_out;
    logic                   go;
    logic                   full;
    logic                   found;
    fcs_pkg::t_cell_ctl     ctl;

    logic [HANDLE_BITS-1:0] cell_h   [DEPTH+1];
    logic [ID_BITS-1:0]     cell_id  [DEPTH+1];
    logic                   seen     [DEPTH+1];
    logic                   first    [DEPTH];
    logic [HANDLE_BITS-1:0] sel_h;
    logic [ID_BITS-1:0]     sel_id;
    logic [HANDLE_BITS-1:0] res_h;
    logic [ID_BITS-1:0]     res_id;
    logic [1:0]             res_st;
    logic [15:0]            res_h16;
    logic [15:0]            res_id16;
    logic [4:0]             res_cnt5;

    // input fields cut or zero-extended to storage widths
    for (genvar b = 0; b < HANDLE_BITS; b++) begin : g_in_h
        if (b < 16) begin : g_bit
            assign in_h[b] = i_in_beat.handle[b];
        end else begin : g_zero
            assign in_h[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < ID_BITS; b++) begin : g_in_id
        if (b < 16) begin : g_bit
            assign in_id[b] = i_in_beat.item_id[b];
        end else begin : g_zero
            assign in_id[b] = 1'b0;
        end
    end

    // slot row; the entry past the last slot feeds zeros
    assign cell_h[DEPTH]  = '0;
    assign cell_id[DEPTH] = '0;
    assign seen[0]        = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        fcs_cell #(
            .HANDLE_BITS(HANDLE_BITS),
            .ID_BITS    (ID_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_occ   (CW'(i) < r_count),
            .i_tail  (CW'(i) == r_count),
            .i_head  (i == 0),
            .i_key_h (r_key_h),
            .i_key_id(r_key_id),
            .i_nxt_h (cell_h[i+1]),
            .i_nxt_id(cell_id[i+1]),
            .i_seen  (seen[i]),
            .o_seen  (seen[i+1]),
            .o_first (first[i]),
            .o_h     (cell_h[i]),
            .o_id    (cell_id[i])
        );
    end

    always_comb begin
        sel_h  = '0;
        sel_id = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_h  = sel_h  | ({HANDLE_BITS{first[i]}} & cell_h[i]);
            sel_id = sel_id | ({ID_BITS{first[i]}} & cell_id[i]);
        end
    end

    assign found = seen[DEPTH];
    assign full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_state = r_state;
        go      = 1'b0;
        case (r_state)
            fcs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fcs_pkg::S_CMP;
            end
            fcs_pkg::S_CMP: begin
                n_state = fcs_pkg::S_EXEC;
            end
            fcs_pkg::S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    go      = 1'b1;
                    n_state = fcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl           = '0;
        ctl.cmp       = (r_state == fcs_pkg::S_CMP);
        ctl.search    = (r_kind == fcs_pkg::KIND_CANCEL) || (r_kind == fcs_pkg::KIND_FIND_H)
                        || (r_kind == fcs_pkg::KIND_FIND_ID);
        ctl.by_id     = (r_kind == fcs_pkg::KIND_FIND_ID);
        ctl.head_only = (r_kind == fcs_pkg::KIND_POP);
        ctl.push      = go && (r_kind == fcs_pkg::KIND_PUSH) && !full;
        ctl.remove    = go && ((r_kind == fcs_pkg::KIND_POP) || (r_kind == fcs_pkg::KIND_CANCEL));
    end

    always_comb begin
        res_st  = fcs_pkg::STAT_MISS;
        res_h   = '0;
        res_id  = '0;
        n_count = r_count;
        case (r_kind)
            fcs_pkg::KIND_PUSH: begin
                if (full) begin
                    res_st = fcs_pkg::STAT_FULL;
                end else begin
                    res_st  = fcs_pkg::STAT_OK;
                    n_count = r_count + CW'(1);
                end
            end
            fcs_pkg::KIND_POP, fcs_pkg::KIND_CANCEL: begin
                if (found) begin
                    res_st  = fcs_pkg::STAT_OK;
                    res_h   = sel_h;
                    res_id  = sel_id;
                    n_count = r_count - CW'(1);
                end
            end
            fcs_pkg::KIND_FIND_H, fcs_pkg::KIND_FIND_ID: begin
                if (found) begin
                    res_st = fcs_pkg::STAT_OK;
                    res_h  = sel_h;
                    res_id = sel_id;
                end
            end
            default: begin
                res_st = fcs_pkg::STAT_MISS;
            end
        endcase
    end

    // result fields cut or zero-extended to beat widths
    for (genvar b = 0; b < 16; b++) begin : g_out_w
        if (b < HANDLE_BITS) begin : g_h
            assign res_h16[b] = res_h[b];
        end else begin : g_hz
            assign res_h16[b] = 1'b0;
        end
        if (b < ID_BITS) begin : g_id
            assign res_id16[b] = res_id[b];
        end else begin : g_idz
            assign res_id16[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < 5; b++) begin : g_out_cnt
        if (b < CW) begin : g_c
            assign res_cnt5[b] = n_count[b];
        end else begin : g_cz
            assign res_cnt5[b] = 1'b0;
        end
    end

    always_comb begin
        n_out            = r_out;
        n_out_valid      = r_out_valid && i_out_stall;
        if (go) begin
            n_out.status     = res_st;
            n_out.handle_out = res_h16;
            n_out.id_out     = res_id16;
            n_out.count      = res_cnt5;
            n_out_valid      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcs_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (go) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == fcs_pkg::S_IDLE && i_in_valid) begin
            r_kind   <= fcs_pkg::t_kind'(i_in_beat.kind);
            r_key_h  <= in_h;
            r_key_id <= in_id;
        end
    end

    assign o_in_stall  = (r_state != fcs_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

@@ src/fcs_checker.sv @@
// Port-level checker for the cancelable search queue, bound to the top level.
`include "fifo_with_cancel_and_search_core_macros.svh"

module fcs_checker #(
    parameter int DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input fcs_pkg::t_out_beat i_out_beat
);

    `FCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_beat))
    `FCS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `FCS_ASSERT_NOW(a_full_result, i_clk, i_rst_n, i_out_valid && i_out_beat.status == fcs_pkg::STAT_FULL, i_out_beat.handle_out == 16'd0 && i_out_beat.id_out == 16'd0 && i_out_beat.count == 5'(DEPTH))
    `FCS_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_out_valid && !i_in_stall)

endmodule

bind fifo_with_cancel_and_search_core fcs_checker #(
    .DEPTH(DEPTH)
) u_fcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_beat (o_out_beat)
);
